@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the list engine modules
// depends on: clk and rst being in scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ILE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ILE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ile_pkg.sv @@
// types, codes and defaults for the indexed list engine
// depends on: nothing
`default_nettype none

package ile_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int FIDX_W  = 6;
  localparam int CNT_W   = 7;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_SET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_GET    = 3'd4,
    OP_FIND   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // walk mode of the shift / search engine
  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_INS,
    SCAN_RM,
    SCAN_FIND
  } scan_t;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value_out;
    logic [FIDX_W-1:0]       found_index;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       ld_req;
    logic       set_status;
    logic [1:0] status_code;
    scan_t      scan;
    logic       rd_pos;
    logic       rd_front;
    logic       rd_back;
    logic       wr_append;
    logic       wr_pos;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       ptr_from_count;
    logic       ptr_from_pos;
    logic       ptr_zero;
    logic       take_vout;
    logic       take_fidx;
    logic       take_front;
    logic       take_back;
  } ile_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic full;
    logic scan_idle;
    logic match;
  } ile_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ile_ram.sv @@
// generic single-write, single-read RAM with registered read data
// depends on: nothing
`default_nettype none

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ile_ctrl.sv @@
// sequencing state machine of the indexed list engine
// depends on: ile_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ile_ctrl import ile_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ile_stat_t stat,
  output ile_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_SHIFT,
    S_RM_VAL,
    S_RM_SHIFT,
    S_GET_WAIT,
    S_FIND,
    S_FRONT,
    S_BACK,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   done_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.scan   = SCAN_NONE;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FRONT;
        case (stat.op)
          OP_APPEND: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
              cmd.cnt_inc   = 1'b1;
            end
          end
          OP_INSERT: begin
            if (stat.pos_gt_cnt) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_POS;
            end else if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.ptr_from_count = 1'b1;
              state_next         = S_INS_SHIFT;
            end
          end
          OP_SET: begin
            if (stat.pos_ge_cnt) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_POS;
            end else begin
              cmd.wr_pos = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (stat.pos_ge_cnt) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_POS;
            end else begin
              cmd.rd_pos = 1'b1;
              state_next = S_RM_VAL;
            end
          end
          OP_GET: begin
            if (stat.pos_ge_cnt) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_POS;
            end else begin
              cmd.rd_pos = 1'b1;
              state_next = S_GET_WAIT;
            end
          end
          OP_FIND: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_NOT_FOUND;
            cmd.ptr_zero    = 1'b1;
            state_next      = S_FIND;
          end
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_INS_SHIFT: begin
        cmd.scan = SCAN_INS;
        if (stat.scan_idle) begin
          cmd.wr_pos  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_FRONT;
        end
      end
      S_RM_VAL: begin
        cmd.take_vout    = 1'b1;
        cmd.ptr_from_pos = 1'b1;
        state_next       = S_RM_SHIFT;
      end
      S_RM_SHIFT: begin
        cmd.scan = SCAN_RM;
        if (stat.scan_idle) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FRONT;
        end
      end
      S_GET_WAIT: begin
        cmd.take_vout = 1'b1;
        state_next    = S_FRONT;
      end
      S_FIND: begin
        cmd.scan = SCAN_FIND;
        if (stat.match) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          cmd.take_fidx   = 1'b1;
          state_next      = S_FRONT;
        end else if (stat.scan_idle) begin
          state_next = S_FRONT;
        end
      end
      S_FRONT: begin
        cmd.rd_front = 1'b1;
        state_next   = S_BACK;
      end
      S_BACK: begin
        cmd.rd_back    = 1'b1;
        cmd.take_front = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        cmd.take_back = 1'b1;
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  `ILE_ASSERT_IMPL(a_done_when_idle, done, !busy)
  `ILE_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
  `ILE_ASSERT_NEXT(a_done_single, done, !done)

endmodule

`default_nettype wire

@@ hw/rtl/ile_dpath.sv @@
// element store, count, walk pointer and result registers of the list engine
// depends on: ile_pkg, ile_ram, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ile_dpath import ile_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  request,
  input  ile_cmd_t  cmd,
  output ile_stat_t stat,
  output out_word_t result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  in_word_t                req;
  logic [CW-1:0]           count;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           ptr_d;
  logic                    val_d;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] value_out;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] back_value;
  logic [FIDX_W-1:0]       found_index;

  logic             rd_en, wr_en, issue;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data, rd_data;
  logic [XW-1:0]    pos_x, cnt_x, ptr_x;

  assign pos_x = XW'(req.position);
  assign cnt_x = XW'(count);
  assign ptr_x = XW'(ptr);

  // issue one read per cycle while the walk has entries left
  always_comb begin
    case (cmd.scan)
      SCAN_INS:  issue = (ptr_x > pos_x);
      SCAN_RM:   issue = ((CW+1)'(ptr) + (CW+1)'(1) < (CW+1)'(count));
      SCAN_FIND: issue = (ptr < count);
      default:   issue = 1'b0;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (issue) begin
      rd_en = 1'b1;
      case (cmd.scan)
        SCAN_INS: rd_addr = AW'(ptr - CW'(1));
        SCAN_RM:  rd_addr = AW'(ptr + CW'(1));
        default:  rd_addr = AW'(ptr);
      endcase
    end else if (cmd.rd_pos) begin
      rd_en   = 1'b1;
      rd_addr = AW'(req.position);
    end else if (cmd.rd_front) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.rd_back) begin
      rd_en   = 1'b1;
      rd_addr = AW'(count - CW'(1));
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(ptr_d);
    wr_data = rd_data;
    if (val_d && (cmd.scan == SCAN_INS || cmd.scan == SCAN_RM)) begin
      wr_en = 1'b1;
    end else if (cmd.wr_append) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count);
      wr_data = req.value_in;
    end else if (cmd.wr_pos) begin
      wr_en   = 1'b1;
      wr_addr = AW'(req.position);
      wr_data = req.value_in;
    end
  end

  ile_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.op         = op_t'(req.operation);
    stat.pos_gt_cnt = (pos_x > cnt_x);
    stat.pos_ge_cnt = (pos_x >= cnt_x);
    stat.full       = (count == CW'(CAPACITY));
    stat.scan_idle  = !issue && !val_d;
    stat.match      = val_d && (rd_data == req.value_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      val_d <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      val_d <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req         <= request;
      status      <= ST_OK;
      value_out   <= '0;
      found_index <= '0;
    end
    if (cmd.set_status) begin
      status <= cmd.status_code;
    end
    if (cmd.ptr_from_count) begin
      ptr <= count;
    end else if (cmd.ptr_from_pos) begin
      ptr <= CW'(req.position);
    end else if (cmd.ptr_zero) begin
      ptr <= '0;
    end else if (issue) begin
      ptr <= (cmd.scan == SCAN_INS) ? ptr - CW'(1) : ptr + CW'(1);
    end
    if (issue) begin
      ptr_d <= ptr;
    end
    if (cmd.take_vout) begin
      value_out <= rd_data;
    end
    if (cmd.take_fidx) begin
      found_index <= FIDX_W'(ptr_d);
    end
    if (cmd.take_front) begin
      front_value <= (count == '0) ? '0 : rd_data;
    end
    if (cmd.take_back) begin
      back_value <= (count == '0) ? '0 : rd_data;
    end
  end

  always_comb begin
    result.status      = status;
    result.value_out   = value_out;
    result.found_index = found_index;
    result.count       = CNT_W'(count);
    result.front_value = front_value;
    result.back_value  = back_value;
  end

  `ILE_ASSERT_IMPL(a_count_bounded, 1'b1, count <= CW'(CAPACITY))
  `ILE_ASSERT_IMPL(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr)

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_engine.sv @@
// top level of the indexed list engine: controller plus datapath
// depends on: ile_pkg, ile_ctrl, ile_dpath (and through it ile_ram)
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in one RAM.
// A request word (operation, position, value_in) is taken at a clock edge
// where start is high and busy is low; busy then stays high until the
// result word is shown. The result word is marked by done, high for
// exactly one cycle, and there is no way to hold it off: capture it
// in that cycle. In the done cycle busy is already low, so the next
// request may be taken at the same edge that ends the result.
// Every request passes the check state, then the work of its operation,
// then reads of the front and back entries and a finish state before
// done. Append, set, clear, code 7 and rejected requests go straight
// to the front read; get waits for the read of its entry; insert shifts
// the entries from position up by one, remove reads its entry and shifts
// the entries above it down, and find walks from index 0 to the first
// match, or to the count when nothing matches. The store's one read port
// has registered data; shifts and searches move one entry per cycle.
// Each result carries count, front_value and back_value after the
// operation; front and back read as zero while the list is empty.
// Only entries below the count reach a result, so the store needs no
// clearing after reset.

module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  request,
  output logic      done,
  output out_word_t result
);

  // command and status buses between the sequencer and the datapath
  ile_cmd_t  cmd;
  ile_stat_t stat;

  ile_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // holds the store, count, walk pointer and the result word
  ile_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

`default_nettype wire
